### rtl/ppds_pkg.sv
// Shared types and constants of the pairwise proximity danger shader.
package ppds_pkg;

    // Widths fixed by the box fields.
    localparam int unsigned CLS_W   = 8;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned FOOT_W  = 13;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned LEVEL_W = 8;

    // Fixed-point widths: distance Q14.4, terms Q0.12 and sum Q1.12.
    localparam int unsigned H16_W   = 16;
    localparam int unsigned DIST_W  = 18;
    localparam int unsigned SQ_W    = 26;
    localparam int unsigned RAD_W   = 36;
    localparam int unsigned TERM_W  = 12;
    localparam int unsigned SUM_W   = 13;
    localparam int unsigned PROD_W  = 21;

    localparam logic [DIST_W-1:0]  DIST_MAX  = 18'd131071;
    localparam logic [SUM_W-1:0]   SUM_ONE   = 13'd4096;
    localparam logic [7:0]         LVL_SCALE = 8'd153;
    localparam logic [LEVEL_W-1:0] LVL_BASE  = 8'd51;
    localparam logic [PROD_W-1:0]  LVL_HALF  = 21'd2048;

    // Register byte address of person_class.
    localparam logic [2:0] ADDR_PERSON_CLASS = 3'd0;

    // One stored box.
    typedef struct packed {
        logic [CLS_W-1:0]   cls;
        logic [FOOT_W-1:0]  fx;
        logic [FOOT_W-1:0]  fy;
        logic [COORD_W-1:0] h;
    } t_box;

endpackage

### rtl/ppds_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module ppds_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ppds_pkg::RAD_W-1:0]        i_radicand,
    output logic                              o_done,
    output logic [ppds_pkg::DIST_W-1:0]       o_root
);

    logic [ppds_pkg::RAD_W-1:0]  r_rad;
    logic [19:0]                 r_rem;
    logic [ppds_pkg::DIST_W-1:0] r_root;
    logic [4:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [21:0]                 rem_sh;
    logic [21:0]                 trial;

    // One restoring step on the next two radicand bits.
    assign rem_sh = {r_rem, r_rad[ppds_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ppds_pkg::DIST_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[ppds_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= 20'(rem_sh - trial);
                r_root <= {r_root[ppds_pkg::DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[19:0];
                r_root <= {r_root[ppds_pkg::DIST_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/ppds_div.sv
// Iterative restoring divider for one Q0.12 danger term.
module ppds_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ppds_pkg::H16_W-1:0]       i_num,
    input  logic [ppds_pkg::H16_W-1:0]       i_den,
    output logic                             o_done,
    output logic [ppds_pkg::TERM_W-1:0]      o_quot
);

    logic [ppds_pkg::H16_W-1:0]  r_rem;
    logic [ppds_pkg::H16_W-1:0]  r_den;
    logic [ppds_pkg::TERM_W-1:0] r_quot;
    logic [3:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [ppds_pkg::H16_W:0]    rem_sh;

    // The numerator is at most the divisor, so each step yields one fraction bit.
    assign rem_sh = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(ppds_pkg::TERM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem  <= 16'(rem_sh - {1'b0, r_den});
                r_quot <= {r_quot[ppds_pkg::TERM_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[ppds_pkg::H16_W-1:0];
                r_quot <= {r_quot[ppds_pkg::TERM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/pairwise_proximity_danger_shader.sv
// Top level: box memory, frame sequencer, danger accumulation and result register.
//
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    object_class, box_left/top/width/height, frame_end
// out      output     o_out_valid / i_out_stall  object_index, is_person, color_level,
//                                                overflow, last_result
// cfg      input      APB psel/penable/pready    person_class at byte address 0
//
// Boxes are taken back to back while loading. After frame close each stored box is read,
// checked, levelled and emitted; a person box also reads every stored box and, for every other
// person box, runs the 18-step square root, plus the 12-step divider if the pair is close enough.
// Reset clears the state, the count, the dropped flag, the register and the result valid.
// Input stalls from frame close until the last result is loaded; a stalled output holds.
module pairwise_proximity_danger_shader #(
    parameter int unsigned MAX_BOXES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_object_class,
    input  logic [11:0] i_box_left,
    input  logic [11:0] i_box_top,
    input  logic [11:0] i_box_width,
    input  logic [11:0] i_box_height,
    input  logic        i_frame_end,
    // Result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_object_index,
    output logic        o_is_person,
    output logic [7:0]  o_color_level,
    output logic        o_overflow,
    output logic        o_last_result,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_RD_CUR = 10'b0000000010,
        S_CUR    = 10'b0000000100,
        S_RD_J   = 10'b0000001000,
        S_J      = 10'b0000010000,
        S_MUL    = 10'b0000100000,
        S_SQRT   = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_LEVEL  = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    ppds_pkg::t_box mem [MAX_BOXES];
    ppds_pkg::t_box r_rd_data;
    ppds_pkg::t_box r_cur;
    ppds_pkg::t_box wr_box;
    logic [AW-1:0]  rd_addr;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_j;
    logic          r_dropped;
    logic [7:0]    r_person_class;

    logic [ppds_pkg::FOOT_W-1:0] r_dx;
    logic [ppds_pkg::FOOT_W-1:0] r_dy;
    logic [ppds_pkg::SQ_W-1:0]   sq_x;
    logic [ppds_pkg::SQ_W-1:0]   sq_y;
    logic [ppds_pkg::SUM_W-1:0]  r_sum;
    logic [ppds_pkg::PROD_W-1:0] r_prod;
    logic                        r_cur_person;

    logic        r_out_valid;
    logic [5:0]  r_out_index;
    logic        r_out_person;
    logic [7:0]  r_out_level;
    logic        r_out_overflow;
    logic        r_out_last;

    logic in_acc;
    logic cfg_wr;
    logic sq_start;
    logic sq_done;
    logic dv_start;
    logic dv_done;
    logic out_free;
    logic j_last;
    logic [ppds_pkg::DIST_W-1:0]   sq_root;
    logic [ppds_pkg::DIST_W-1:0]   dist_sat;
    logic [ppds_pkg::H16_W-1:0]    cur_h16;
    logic [ppds_pkg::TERM_W-1:0]   dv_quot;
    logic [ppds_pkg::SUM_W:0]      sum_add;
    logic [ppds_pkg::PROD_W-1:0]   level_rnd;
    logic [ppds_pkg::RAD_W-1:0]    radicand;

    assign in_acc     = i_in_valid && (r_state == S_LOAD);
    assign o_in_stall = (r_state != S_LOAD);
    assign cfg_wr     = psel && penable && pwrite && (paddr == ppds_pkg::ADDR_PERSON_CLASS);
    assign pready     = 1'b1;
    assign prdata     = (paddr == ppds_pkg::ADDR_PERSON_CLASS) ? {24'd0, r_person_class}
                                                              : 32'd0;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign j_last     = (r_j + CW'(1)) == r_count;
    assign cur_h16    = {r_cur.h, 4'd0};
    assign dist_sat   = (sq_root > ppds_pkg::DIST_MAX) ? ppds_pkg::DIST_MAX : sq_root;

    // Squares of the foot-point differences feed the square root as it starts.
    assign sq_x       = ppds_pkg::SQ_W'(r_dx) * ppds_pkg::SQ_W'(r_dx);
    assign sq_y       = ppds_pkg::SQ_W'(r_dy) * ppds_pkg::SQ_W'(r_dy);
    assign radicand   = {1'b0, 27'({1'b0, sq_x} + {1'b0, sq_y}), 8'd0};
    assign sq_start   = (r_state == S_MUL);
    assign dv_start   = (r_state == S_SQRT) && sq_done && ({2'b00, cur_h16} > dist_sat);
    assign sum_add    = {1'b0, r_sum} + {2'b00, dv_quot};
    assign level_rnd  = r_prod + ppds_pkg::LVL_HALF;

    // Foot point: bottom center with the half-width truncated.
    always_comb begin
        wr_box.cls = i_object_class;
        wr_box.fx  = {1'b0, i_box_left} + {2'b00, i_box_width[11:1]};
        wr_box.fy  = {1'b0, i_box_top} + {1'b0, i_box_height};
        wr_box.h   = i_box_height;
    end

    // Read address follows the loop that is running.
    assign rd_addr = (r_state == S_RD_CUR) ? r_k[AW-1:0] : r_j[AW-1:0];

    // Box memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < CW'(MAX_BOXES))) begin
            mem[r_count[AW-1:0]] <= wr_box;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_person_class <= '0;
        end else if (cfg_wr) begin
            r_person_class <= pwdata[7:0];
        end
    end

    // Next state of the frame sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && i_frame_end) n_state = S_RD_CUR;
            end
            S_RD_CUR: n_state = S_CUR;
            S_CUR: begin
                if (r_rd_data.cls == r_person_class) n_state = S_RD_J;
                else n_state = S_LEVEL;
            end
            S_RD_J: n_state = S_J;
            S_J: begin
                if ((r_j != r_k) && (r_rd_data.cls == r_person_class)) n_state = S_MUL;
                else if (j_last) n_state = S_LEVEL;
                else n_state = S_RD_J;
            end
            S_MUL: n_state = S_SQRT;
            S_SQRT: begin
                if (sq_done) begin
                    if (dv_start) n_state = S_DIV;
                    else if (j_last) n_state = S_LEVEL;
                    else n_state = S_RD_J;
                end
            end
            S_DIV: begin
                if (dv_done) begin
                    if (j_last) n_state = S_LEVEL;
                    else n_state = S_RD_J;
                end
            end
            S_LEVEL: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    if ((r_k + CW'(1)) == r_count) n_state = S_LOAD;
                    else n_state = S_RD_CUR;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control registers: state, count, indices and dropped flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (r_count < CW'(MAX_BOXES)) r_count <= r_count + CW'(1);
                else r_dropped <= 1'b1;
                r_k <= '0;
            end
            if (r_state == S_CUR) r_j <= '0;
            if ((n_state == S_RD_J) && (r_state != S_CUR)) r_j <= r_j + CW'(1);
            if ((r_state == S_EMIT) && out_free) begin
                if ((r_k + CW'(1)) == r_count) begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                end else begin
                    r_k <= r_k + CW'(1);
                end
            end
        end
    end

    // Pair datapath: differences, accumulation and level product.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CUR) begin
            r_cur        <= r_rd_data;
            r_cur_person <= (r_rd_data.cls == r_person_class);
            r_sum        <= '0;
        end
        if (r_state == S_J) begin
            r_dx <= (r_cur.fx > r_rd_data.fx) ? r_cur.fx - r_rd_data.fx
                                             : r_rd_data.fx - r_cur.fx;
            r_dy <= (r_cur.fy > r_rd_data.fy) ? r_cur.fy - r_rd_data.fy
                                             : r_rd_data.fy - r_cur.fy;
        end
        if ((r_state == S_DIV) && dv_done) begin
            r_sum <= (sum_add > {1'b0, ppds_pkg::SUM_ONE}) ? ppds_pkg::SUM_ONE
                                                           : sum_add[ppds_pkg::SUM_W-1:0];
        end
        if (r_state == S_LEVEL) begin
            r_prod <= ppds_pkg::PROD_W'(ppds_pkg::LVL_SCALE) * ppds_pkg::PROD_W'(r_sum);
        end
    end

    // Result register, loaded when empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_index    <= 6'(r_k);
            r_out_person   <= r_cur_person;
            r_out_level    <= r_cur_person ? ppds_pkg::LVL_BASE + level_rnd[19:12] : 8'd0;
            r_out_overflow <= r_dropped;
            r_out_last     <= (r_k + CW'(1)) == r_count;
        end
    end

    ppds_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (radicand),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    ppds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (16'(cur_h16 - dist_sat[15:0])),
        .i_den   (cur_h16),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    assign o_out_valid    = r_out_valid;
    assign o_object_index = r_out_index;
    assign o_is_person    = r_out_person;
    assign o_color_level  = r_out_level;
    assign o_overflow     = r_out_overflow;
    assign o_last_result  = r_out_last;

`ifndef SYNTHESIS
    // The box count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOXES)) else $error("box count above capacity");

    // The danger sum stays saturated at one when the level is formed.
    a_sum_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LEVEL |-> r_sum <= ppds_pkg::SUM_ONE) else $error("danger sum above one");

    // A non-person result carries a zero level.
    a_nonperson_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_person |-> o_color_level == 8'd0)
        else $error("non-person result with color level");

    // Input is taken only while loading.
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> r_state == S_LOAD) else $error("input open outside load");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the pairwise proximity danger shader.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BOXES  = 64;
    localparam int unsigned DRAIN_WAIT = 200;
    localparam longint unsigned LIMIT  = 64'd2_000_000;

    // Expected result of one box.
    typedef struct packed {
        logic [ppds_pkg::IDX_W-1:0]   index;
        logic                         person;
        logic [ppds_pkg::LEVEL_W-1:0] level;
        logic                         ovf;
        logic                         last;
    } t_shade;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_object_class;
    logic [11:0] i_box_left;
    logic [11:0] i_box_top;
    logic [11:0] i_box_width;
    logic [11:0] i_box_height;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_object_index;
    logic        o_is_person;
    logic [7:0]  o_color_level;
    logic        o_overflow;
    logic        o_last_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    ppds_pkg::t_box frame_boxes [MAX_BOXES];
    int unsigned frame_count;
    logic        frame_dropped;
    logic [7:0]  person_cls;

    t_shade      shade_queue[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned frames_sent;
    longint unsigned cycles = 0;
    bit          hold_output;
    bit          sink_random;

    pairwise_proximity_danger_shader #(.MAX_BOXES(MAX_BOXES)) u_dut (.*);

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Floor square root.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Danger sum of box i in Q1.12, saturated at one.
    function automatic int unsigned danger_sum(int unsigned i);
        int unsigned     sum;
        longint unsigned h16;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned dist_q;
        sum = 0;
        h16 = frame_boxes[i].h * 16;
        for (int unsigned j = 0; j < frame_count; j++) begin
            if (j == i || frame_boxes[j].cls != person_cls) continue;
            dx = (frame_boxes[i].fx > frame_boxes[j].fx) ?
                 frame_boxes[i].fx - frame_boxes[j].fx : frame_boxes[j].fx - frame_boxes[i].fx;
            dy = (frame_boxes[i].fy > frame_boxes[j].fy) ?
                 frame_boxes[i].fy - frame_boxes[j].fy : frame_boxes[j].fy - frame_boxes[i].fy;
            dist_q = floor_sqrt((dx * dx + dy * dy) * 256);
            if (dist_q > ppds_pkg::DIST_MAX) dist_q = ppds_pkg::DIST_MAX;
            if (h16 <= dist_q) continue;
            sum += int'(((h16 - dist_q) * 4096) / h16);
            if (sum > 4096) sum = 4096;
        end
        return sum;
    endfunction

    // Store one accepted box and predict the frame's results on its close.
    task automatic predict_box(logic [7:0] cls, logic [11:0] l, logic [11:0] t,
                               logic [11:0] w, logic [11:0] h, logic fe);
        t_shade      s;
        int unsigned dsum;
        if (frame_count < MAX_BOXES) begin
            frame_boxes[frame_count].cls = cls;
            frame_boxes[frame_count].fx  = l + (w >> 1);
            frame_boxes[frame_count].fy  = t + h;
            frame_boxes[frame_count].h   = h;
            frame_count++;
        end else begin
            frame_dropped = 1'b1;
        end
        if (!fe) return;
        for (int unsigned k = 0; k < frame_count; k++) begin
            s.index  = k[ppds_pkg::IDX_W-1:0];
            s.person = (frame_boxes[k].cls == person_cls);
            s.level  = 0;
            if (s.person) begin
                dsum = danger_sum(k);
                s.level = ppds_pkg::LVL_BASE + (153 * dsum + 2048) / 4096;
            end
            s.ovf  = frame_dropped;
            s.last = (k + 1 == frame_count);
            shade_queue.push_back(s);
        end
        frame_count   = 0;
        frame_dropped = 1'b0;
        frames_sent++;
    endtask

    // Short gap: mostly zero or short, sometimes long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Send one box and wait for it to be accepted; valid stays up for a following item.
    task automatic send_box(logic [7:0] cls, logic [11:0] l, logic [11:0] t,
                            logic [11:0] w, logic [11:0] h, logic fe);
        i_in_valid     <= 1'b1;
        i_object_class <= cls;
        i_box_left     <= l;
        i_box_top      <= t;
        i_box_width    <= w;
        i_box_height   <= h;
        i_frame_end    <= fe;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_box(cls, l, t, w, h, fe);
        @(negedge i_clk);
    endtask

    // Send with a random gap before it.
    task automatic send_gap(logic [7:0] cls, logic [11:0] l, logic [11:0] t,
                            logic [11:0] w, logic [11:0] h, logic fe, bit gaps);
        int unsigned g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        send_box(cls, l, t, w, h, fe);
    endtask

    // Drop valid, wait until every expected result is in, then let the block settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (shade_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // APB write of the person class.
    task automatic write_person_class(logic [7:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ppds_pkg::ADDR_PERSON_CLASS;
        pwdata  <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        person_cls = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random person-biased frame of n boxes, most of them near one another.
    task automatic random_frame(int unsigned n, bit gaps);
        logic [7:0]  cls;
        logic [11:0] cx;
        logic [11:0] cy;
        cx = $urandom_range(0, 3800);
        cy = $urandom_range(0, 3800);
        for (int unsigned k = 0; k < n; k++) begin
            cls = ($urandom_range(0, 3) != 0) ? person_cls : 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                send_gap(cls, 12'($urandom), 12'($urandom), 12'($urandom),
                         12'($urandom), k + 1 == n, gaps);
            else
                send_gap(cls, cx + 12'($urandom_range(0, 250)),
                         cy + 12'($urandom_range(0, 250)),
                         12'($urandom_range(0, 200)), 12'($urandom_range(0, 300)),
                         k + 1 == n, gaps);
        end
    endtask

    // Output stall driver.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_output) i_out_stall <= hold_output;
        else if (sink_random) i_out_stall <= ($urandom_range(0, 9) < 3);
        else i_out_stall <= 1'b0;
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_shade e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (shade_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result index %0d", o_object_index);
            end else begin
                e = shade_queue.pop_front();
                if (o_object_index !== e.index || o_is_person !== e.person ||
                    o_color_level !== e.level || o_overflow !== e.ovf ||
                    o_last_result !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch idx/p/lvl/ovf/last exp %0d/%0d/%0d/%0d/%0d %s",
                                 e.index, e.person, e.level, e.ovf, e.last,
                                 $sformatf("got %0d/%0d/%0d/%0d/%0d", o_object_index,
                                           o_is_person, o_color_level, o_overflow,
                                           o_last_result));
                end
            end
        end
    end

    // Directed: extremes, zero height, single box, overlapping persons, non-persons.
    task automatic test_directed();
        send_box(8'd0, 12'd100, 12'd100, 12'd20, 12'd50, 1'b1);
        send_box(8'd0, 12'd100, 12'd100, 12'd20, 12'd50, 1'b0);
        send_box(8'd0, 12'd100, 12'd100, 12'd20, 12'd50, 1'b0);
        send_box(8'd0, 12'd110, 12'd90, 12'd0, 12'd60, 1'b0);
        send_box(8'd255, 12'd100, 12'd100, 12'd20, 12'd50, 1'b0);
        send_box(8'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
        send_box(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_box(8'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
        send_box(8'd7, 12'd0, 12'd0, 12'd4095, 12'd0, 1'b0);
        send_box(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        wait_idle();
    endtask

    // Person class changes, extremes included, each written while the block is idle.
    task automatic test_person_class();
        write_person_class(8'd255);
        random_frame(6, 1);
        wait_idle();
        write_person_class(8'd170);
        random_frame(5, 1);
        wait_idle();
        write_person_class(8'd85);
        random_frame(4, 1);
        wait_idle();
        write_person_class(8'd0);
    endtask

    // Capacity overflow: more boxes than the store holds.
    task automatic test_overflow();
        for (int unsigned k = 0; k < MAX_BOXES + 3; k++)
            send_box(k[1:0] == 0 ? 8'd9 : person_cls, 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), k == MAX_BOXES + 2);
        wait_idle();
    endtask

    // Random frames with idling on both sides.
    task automatic test_random();
        sink_random = 1'b1;
        while (frames_sent < 13) random_frame($urandom_range(1, 5), $urandom_range(0, 1));
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps going, then sender waits for drain.
    task automatic test_backpressure();
        int unsigned hold;
        hold = 400;
        fork
            begin
                hold_output = 1'b1;
                repeat (hold) @(negedge i_clk);
                hold_output = 1'b0;
            end
            begin
                random_frame(3, 0);
                random_frame(2, 0);
            end
        join
        wait_idle();
        random_frame(3, 0);
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_object_class = '0;
        i_box_left = '0;
        i_box_top = '0;
        i_box_width = '0;
        i_box_height = '0;
        i_frame_end = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        frame_count = 0;
        frame_dropped = 1'b0;
        person_cls = 8'd0;
        frames_sent = 0;
        hold_output = 1'b0;
        sink_random = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_person_class();
        test_overflow();
        test_backpressure();
        test_random();

        wait_idle();
        $display("Covered %0d frames and %0d results: extremes, class changes, overflow,",
                 frames_sent, results_seen);
        $display("output hold-off and random idling on both sides.");
        if (mismatches == 0 && shade_queue.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, shade_queue.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
